[src/fcb_pkg.sv]
// shared types and constants for the frame crossfade blender
`timescale 1ns / 1ps
`default_nettype none

package fcb_pkg;

   localparam int CH_W       = 8;
   localparam int DUR_W      = 16;
   localparam int FRAC_BITS  = 16;
   localparam int WEIGHT_W   = FRAC_BITS + 1;
   localparam int ACC_W      = CH_W + WEIGHT_W;
   localparam int DIV_STEPS  = WEIGHT_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_BITS;
   localparam logic [ACC_W-1:0]    ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic [DUR_W-1:0]    FADE_RESET = DUR_W'(1);

   typedef struct packed {
      logic [CH_W-1:0] a_red;
      logic [CH_W-1:0] a_green;
      logic [CH_W-1:0] a_blue;
      logic [CH_W-1:0] b_red;
      logic [CH_W-1:0] b_green;
      logic [CH_W-1:0] b_blue;
      logic            frame_start;
      logic            frame_last;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] out_red;
      logic [CH_W-1:0] out_green;
      logic [CH_W-1:0] out_blue;
      logic            end_of_frame;
      logic            fade_done;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DUR_W-1:0] numer;
      logic [DUR_W-1:0] denom;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [WEIGHT_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

[src/frame_crossfade_blender_unit.sv]
// top level of the frame crossfade blender: control, weight state, lanes, output register
`timescale 1ns / 1ps
`default_nettype none

// usage
// - req channel (valid/ready) carries one pixel pair per beat: color a of the
//   outgoing frame, color b of the incoming frame, frame_start and frame_last
// - rsp channel (valid/ready) returns one blended pixel per beat, with
//   end_of_frame copied from frame_last and fade_done on a last pixel once the
//   fade has run its full duration
// - csr_we / csr_wdata write the fade length in frames (0 acts as 1); a write
//   restarts the fade from frame a; write only while the block is idle
// latency and throughput
// - a pixel without frame_start is blended combinationally and shows on rsp the
//   cycle after its beat; such pixels stream at one per cycle while rsp is not stalled
// - a frame_start pixel advances the frame counter and runs the 17 step
//   restoring divider for the new weight, one quotient bit per cycle; its
//   result shows on rsp once the new weight is registered; req_ready is low meanwhile
// reset
// - synchronous, active high: fade length 1, counter and weight 0, no result
//   pending; no clearing pass
// stall
// - the output register holds a result until rsp_ready; req_ready is high while
//   idle with that register empty or drained in the same cycle, else it drops

module frame_crossfade_blender_unit (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  fcb_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output fcb_pkg::rsp_type               rsp_data,
   input  wire                            csr_we,
   input  wire [fcb_pkg::DUR_W-1:0]       csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_BLEND
   } state_type;

   state_type                    state_ff, state_in;
   logic [fcb_pkg::DUR_W-1:0]    fade_ff, fade_in;
   logic [fcb_pkg::DUR_W-1:0]    elapsed_ff, elapsed_in;
   logic [fcb_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   fcb_pkg::req_type             hold_ff, hold_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   fcb_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic [fcb_pkg::DUR_W-1:0]    dur;
   logic [fcb_pkg::DUR_W-1:0]    elapsed_next;
   logic                         out_free;
   logic                         accept;
   logic                         load_out;
   fcb_pkg::req_type             pix;
   fcb_pkg::div_cmd_type         div_cmd;
   fcb_pkg::div_rsp_type         div_rsp;
   logic [fcb_pkg::CH_W-1:0]     mix_red, mix_green, mix_blue;

   // zero length behaves as one frame
   assign dur = (fade_ff == '0) ? fcb_pkg::DUR_W'(1) : fade_ff;

   // counter saturates at the duration
   assign elapsed_next = (elapsed_ff < dur) ? (elapsed_ff + 1'b1) : dur;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // lanes see the live beat, or the held frame_start pixel once its weight is in
   assign pix = (state_ff == ST_BLEND) ? hold_ff : req_data;

   assign div_cmd.start = accept && req_data.frame_start;
   assign div_cmd.numer = elapsed_next;
   assign div_cmd.denom = dur;

   fcb_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   fcb_lane u_lane_red (
      .chan_a (pix.a_red),
      .chan_b (pix.b_red),
      .weight (weight_ff),
      .mix    (mix_red)
   );

   fcb_lane u_lane_green (
      .chan_a (pix.a_green),
      .chan_b (pix.b_green),
      .weight (weight_ff),
      .mix    (mix_green)
   );

   fcb_lane u_lane_blue (
      .chan_a (pix.a_blue),
      .chan_b (pix.b_blue),
      .weight (weight_ff),
      .mix    (mix_blue)
   );

   always_comb begin
      state_in     = state_ff;
      fade_in      = fade_ff;
      elapsed_in   = elapsed_ff;
      weight_in    = weight_ff;
      hold_in      = hold_ff;
      load_out     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               fade_in    = csr_wdata;
               elapsed_in = '0;
               weight_in  = '0;
            end else if (accept) begin
               if (req_data.frame_start) begin
                  elapsed_in = elapsed_next;
                  hold_in    = req_data;
                  state_in   = ST_DIV;
               end else begin
                  load_out = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               weight_in = div_rsp.quot;
               state_in  = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // merge the three lanes and the frame flags into one result beat
      rsp_data_in = rsp_data_ff;
      if (load_out) begin
         rsp_data_in.out_red      = mix_red;
         rsp_data_in.out_green    = mix_green;
         rsp_data_in.out_blue     = mix_blue;
         rsp_data_in.end_of_frame = pix.frame_last;
         rsp_data_in.fade_done    = pix.frame_last && (elapsed_ff >= dur);
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fade_ff      <= fcb_pkg::FADE_RESET;
         elapsed_ff   <= '0;
         weight_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fade_ff      <= fade_in;
         elapsed_ff   <= elapsed_in;
         weight_ff    <= weight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[src/fcb_div.sv]
// radix-2 restoring divider for the blend weight, elapsed * 2^16 / duration
`timescale 1ns / 1ps
`default_nettype none

module fcb_div (
   input  wire                 clock,
   input  wire                 reset,
   input  fcb_pkg::div_cmd_type cmd,
   output fcb_pkg::div_rsp_type rsp
);

   logic [fcb_pkg::WEIGHT_W-1:0]  rem_ff, rem_in;
   logic [fcb_pkg::WEIGHT_W-1:0]  quot_ff, quot_in;
   logic [fcb_pkg::DUR_W-1:0]     denom_ff, denom_in;
   logic [fcb_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          done_ff, done_in;
   logic                          ge;
   logic [fcb_pkg::WEIGHT_W-1:0]  diff;

   // numerator never exceeds the divisor, so the remainder fits in 17 bits
   assign ge   = rem_ff >= {1'b0, denom_ff};
   assign diff = ge ? (rem_ff - {1'b0, denom_ff}) : rem_ff;

   always_comb begin
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      denom_in = denom_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         rem_in   = {1'b0, cmd.numer};
         denom_in = cmd.denom;
         cnt_in   = fcb_pkg::DIV_CNT_W'(fcb_pkg::DIV_STEPS);
      end else if (cnt_ff != '0) begin
         rem_in  = {diff[fcb_pkg::WEIGHT_W-2:0], 1'b0};
         quot_in = {quot_ff[fcb_pkg::WEIGHT_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == fcb_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      denom_ff <= denom_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

`default_nettype wire

[src/fcb_lane.sv]
// one color lane: a*(1-w) + b*w rounded half up to 8 bits
`timescale 1ns / 1ps
`default_nettype none

module fcb_lane (
   input  wire [fcb_pkg::CH_W-1:0]     chan_a,
   input  wire [fcb_pkg::CH_W-1:0]     chan_b,
   input  wire [fcb_pkg::WEIGHT_W-1:0] weight,
   output logic [fcb_pkg::CH_W-1:0]    mix
);

   logic [fcb_pkg::WEIGHT_W-1:0] inv_w;
   logic [fcb_pkg::ACC_W-1:0]    prod_a;
   logic [fcb_pkg::ACC_W-1:0]    prod_b;
   logic [fcb_pkg::ACC_W-1:0]    acc;

   assign inv_w  = fcb_pkg::WEIGHT_ONE - weight;
   assign prod_a = fcb_pkg::ACC_W'(chan_a) * fcb_pkg::ACC_W'(inv_w);
   assign prod_b = fcb_pkg::ACC_W'(chan_b) * fcb_pkg::ACC_W'(weight);
   // sum stays below 2^24, no clamp
   assign acc    = prod_a + prod_b + fcb_pkg::ROUND_HALF;
   assign mix    = acc[fcb_pkg::FRAC_BITS +: fcb_pkg::CH_W];

endmodule

`default_nettype wire

[src/fcb_checker.sv]
// port-level checks for the frame crossfade blender, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module fcb_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_ready,
   input fcb_pkg::req_type          req_data,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input fcb_pkg::rsp_type          rsp_data
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // a plain pixel shows up the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.frame_start |=> rsp_valid)
      else $error("plain pixel not returned next cycle");

   // a frame start pixel occupies the divider, input closes
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.frame_start |=> !req_ready)
      else $error("input open while weight is computed");

   // fade done only on the last pixel of a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.fade_done || rsp_data.end_of_frame)
      else $error("fade_done outside end of frame");

   // nothing pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind frame_crossfade_blender_unit fcb_checker u_fcb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[test/tb.sv]
// self-checking testbench for the frame crossfade blender unit
`timescale 1ns / 1ps

module tb;

   // longest run of cycles with no beat on either channel before giving up;
   // the worst honest case is the receiver hold plus a weight division
   localparam int QUIET_LIMIT = 4000;
   // length of the forced receiver hold-off
   localparam int HOLD_CYCLES = 300;
   // cycles allowed after the last result before the verdict
   localparam int SETTLE_CYCLES = 25;
   localparam int RANDOM_PIXELS = 1800;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   fcb_pkg::req_type          req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   fcb_pkg::rsp_type          rsp_data;
   logic                      csr_we;
   logic [fcb_pkg::DUR_W-1:0] csr_wdata;

   frame_crossfade_blender_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state: the programmed fade length, frames seen so far and
   // the current blend weight in unsigned q1.16
   logic [fcb_pkg::DUR_W-1:0]    fade_len;
   logic [fcb_pkg::DUR_W-1:0]    frames_seen;
   logic [fcb_pkg::WEIGHT_W-1:0] mix_weight;

   // blended pixels still owed by the block, oldest first
   fcb_pkg::rsp_type expected_pixels[$];

   bit failed;
   bit steady;          // when set neither side idles
   int pixels_sent;
   int holds_asked;
   int holds_done;
   int quiet_cycles;

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // one channel: a*(1-w) + b*w, rounded half up, back to 8 bits
   function automatic logic [fcb_pkg::CH_W-1:0] blend_channel(
      input logic [fcb_pkg::CH_W-1:0] a,
      input logic [fcb_pkg::CH_W-1:0] b);
      logic [31:0] acc;
      acc = 32'(a) * (32'(fcb_pkg::WEIGHT_ONE) - 32'(mix_weight))
            + 32'(b) * 32'(mix_weight) + 32'(fcb_pkg::ROUND_HALF);
      return acc[fcb_pkg::FRAC_BITS +: fcb_pkg::CH_W];
   endfunction

   // advance the fade state for one accepted pixel and queue its result
   task automatic predict_blend(input fcb_pkg::req_type px);
      logic [fcb_pkg::DUR_W:0] dur;
      logic [63:0]             quot;
      fcb_pkg::rsp_type        want;
      // a zero length behaves as a one-frame fade
      dur = (fade_len == '0) ? (fcb_pkg::DUR_W + 1)'(1) : {1'b0, fade_len};
      if (px.frame_start) begin
         // counter saturates at the fade length, so the weight stays at one
         if ({1'b0, frames_seen} < dur)
            frames_seen = frames_seen + 1'b1;
         else
            frames_seen = dur[fcb_pkg::DUR_W-1:0];
         quot = (64'(frames_seen) << fcb_pkg::FRAC_BITS) / 64'(dur);
         mix_weight = (quot > 64'(fcb_pkg::WEIGHT_ONE)) ? fcb_pkg::WEIGHT_ONE
                                                        : quot[fcb_pkg::WEIGHT_W-1:0];
      end
      want.out_red      = blend_channel(px.a_red,   px.b_red);
      want.out_green    = blend_channel(px.a_green, px.b_green);
      want.out_blue     = blend_channel(px.a_blue,  px.b_blue);
      want.end_of_frame = px.frame_last;
      // judged after the advance, so start and last on one pixel see the new count
      want.fade_done    = px.frame_last && ({1'b0, frames_seen} >= dur);
      expected_pixels.push_back(want);
   endtask

   // ---------------------------------------------------------------------
   // pixel builders
   // ---------------------------------------------------------------------

   function automatic fcb_pkg::req_type make_pixel(input logic [7:0] ar,
                                                   input logic [7:0] ag,
                                                   input logic [7:0] ab,
                                                   input logic [7:0] br,
                                                   input logic [7:0] bg,
                                                   input logic [7:0] bb,
                                                   input logic start,
                                                   input logic last);
      fcb_pkg::req_type px;
      px.a_red       = ar;
      px.a_green     = ag;
      px.a_blue      = ab;
      px.b_red       = br;
      px.b_green     = bg;
      px.b_blue      = bb;
      px.frame_start = start;
      px.frame_last  = last;
      return px;
   endfunction

   function automatic fcb_pkg::req_type random_pixel(input logic start, input logic last);
      return make_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        start, last);
   endfunction

   // ---------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------

   // offer one pixel and hold it until the beat; valid is left high so a
   // following pixel can go out back to back
   task automatic send_pixel(input fcb_pkg::req_type px);
      while (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      predict_blend(px);
      pixels_sent = pixels_sent + 1;
   endtask

   // stop offering and wait for every owed result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // program the fade length on an idle block; a write restarts the fade
   task automatic write_fade_len(input logic [fcb_pkg::DUR_W-1:0] frames);
      drain_results();
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= frames;
      @(posedge clock);
      csr_we      <= 1'b0;
      fade_len    = frames;
      frames_seen = '0;
      mix_weight  = '0;
   endtask

   // ---------------------------------------------------------------------
   // receiver side: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------

   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (holds_done != holds_asked) begin
            holds_done = holds_done + 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 19);
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         failed = 1'b1;
      end
   endtask

   // every result beat is matched against the oldest owed pixel
   always @(posedge clock) begin
      fcb_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result, expected nothing, actual %h",
                     $time, rsp_data);
            failed = 1'b1;
         end else begin
            want = expected_pixels.pop_front();
            check_field("out_red",   int'(want.out_red),   int'(rsp_data.out_red));
            check_field("out_green", int'(want.out_green), int'(rsp_data.out_green));
            check_field("out_blue",  int'(want.out_blue),  int'(rsp_data.out_blue));
            check_field("end_of_frame", int'(want.end_of_frame),
                        int'(rsp_data.end_of_frame));
            check_field("fade_done", int'(want.fade_done), int'(rsp_data.fade_done));
         end
      end
   end

   // watchdog: too long without a beat on either channel means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // straight out of reset no frame has started: weight 0, output is frame a
   task automatic test_before_first_start();
      send_pixel(make_pixel(8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 1'b0, 1'b0));
      send_pixel(make_pixel(8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0));
      // last pixel without any start: end of frame but fade not done
      send_pixel(make_pixel(8'h5a, 8'ha5, 8'h3c, 8'hc3, 8'h0f, 8'hf0, 1'b0, 1'b1));
   endtask

   // reset length is one frame: the first start jumps straight to frame b,
   // and further frames hold there with done on every last pixel
   task automatic test_single_frame_fade();
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1));
      send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
      send_pixel(make_pixel(8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc, 1'b0, 1'b1));
      send_pixel(make_pixel(8'hff, 8'h00, 8'h80, 8'h01, 8'hfe, 8'h7f, 1'b1, 1'b1));
   endtask

   // zero length acts as one
   task automatic test_zero_length();
      write_fade_len(16'd0);
      send_pixel(make_pixel(8'hff, 8'h80, 8'h00, 8'h00, 8'h7f, 8'hff, 1'b0, 1'b0));
      send_pixel(make_pixel(8'hff, 8'h80, 8'h00, 8'h00, 8'h7f, 8'hff, 1'b1, 1'b0));
      send_pixel(make_pixel(8'h01, 8'h02, 8'h03, 8'hfd, 8'hfe, 8'hff, 1'b0, 1'b1));
   endtask

   // two-frame fade: weight one half exercises the round-half-up boundary
   task automatic test_half_rounding();
      write_fade_len(16'd2);
      send_pixel(make_pixel(8'h00, 8'hff, 8'h01, 8'h01, 8'h00, 8'h00, 1'b1, 1'b0));
      send_pixel(make_pixel(8'h00, 8'h01, 8'hff, 8'hff, 8'h00, 8'hfe, 1'b0, 1'b1));
      send_pixel(make_pixel(8'h00, 8'hff, 8'h01, 8'h01, 8'h00, 8'h00, 1'b1, 1'b1));
   endtask

   // a write part way through a fade restarts it from frame a
   task automatic test_restart_mid_fade();
      write_fade_len(16'd4);
      send_pixel(random_pixel(1'b1, 1'b0));
      send_pixel(random_pixel(1'b0, 1'b1));
      send_pixel(random_pixel(1'b1, 1'b1));
      write_fade_len(16'd4);
      send_pixel(random_pixel(1'b0, 1'b1));
      send_pixel(random_pixel(1'b1, 1'b1));
   endtask

   // longest fade: the weight barely moves off zero
   task automatic test_longest_fade();
      write_fade_len(16'hffff);
      send_pixel(make_pixel(8'hff, 8'h00, 8'h80, 8'h00, 8'hff, 8'h7f, 1'b1, 1'b0));
      send_pixel(make_pixel(8'hff, 8'h00, 8'h80, 8'h00, 8'hff, 8'h7f, 1'b0, 1'b1));
      send_pixel(make_pixel(8'h80, 8'h7f, 8'h00, 8'h7f, 8'h80, 8'hff, 1'b1, 1'b1));
   endtask

   // receiver holds off for a long stretch while pixels keep coming, so the
   // output register fills and the input has to stall
   task automatic test_output_stall();
      int n;
      write_fade_len(16'd3);
      holds_asked = holds_asked + 1;
      for (n = 0; n < 40; n++)
         send_pixel(random_pixel(n % 10 == 0, n % 10 == 9));
   endtask

   // random fades: mostly well-formed frames, enough of them to run past the
   // end of the short fades, with some frames of random start/last marks mixed in
   task automatic test_random_fades();
      int                        goal;
      int                        phase;
      int                        frames;
      int                        len;
      int                        f;
      int                        p;
      bit                        noisy;
      logic [fcb_pkg::DUR_W-1:0] pick;
      goal  = pixels_sent + RANDOM_PIXELS;
      phase = 0;
      while (pixels_sent < goal) begin
         case (phase % 8)
            0: begin
               pick = '0;
            end
            1: begin
               pick = 16'hffff;
            end
            2: begin
               pick = fcb_pkg::DUR_W'($urandom_range(16'hffff));
            end
            default: begin
               pick = fcb_pkg::DUR_W'($urandom_range(1, 12));
            end
         endcase
         write_fade_len(pick);
         // a long stretch without idling on either side
         steady = (phase == 3 || phase == 4);
         // a few pixels before the first start still show frame a
         repeat ($urandom_range(2)) send_pixel(random_pixel(1'b0, 1'b0));
         frames = (pick <= 12) ? int'(pick + $urandom_range(1, 3))
                               : int'($urandom_range(2, 5));
         for (f = 0; f < frames; f++) begin
            len   = int'($urandom_range(1, 8));
            noisy = ($urandom_range(7) == 0);
            for (p = 0; p < len; p++) begin
               if (noisy)
                  send_pixel(random_pixel(1'($urandom_range(1)), 1'($urandom_range(1))));
               else
                  send_pixel(random_pixel(p == 0, p == len - 1));
            end
         end
         phase = phase + 1;
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_we      <= 1'b0;
      csr_wdata   <= '0;
      reset       <= 1'b1;
      failed      = 1'b0;
      steady      = 1'b0;
      pixels_sent = 0;
      holds_asked = 0;
      holds_done  = 0;
      // state after reset
      fade_len    = fcb_pkg::FADE_RESET;
      frames_seen = '0;
      mix_weight  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_before_first_start();
      test_single_frame_fade();
      test_zero_length();
      test_half_rounding();
      test_restart_mid_fade();
      test_longest_fade();
      test_output_stall();
      test_random_fades();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (!failed && expected_pixels.size() == 0) begin
         $display("All tests passed");
      end else begin
         if (expected_pixels.size() != 0)
            $display("%0t: %0d results never arrived", $time, expected_pixels.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
